[rtl/sdlm_pkg.sv]
// Shared constants, types and the log2 fraction table of the stereo level meter.
`default_nettype none

package sdlm_pkg;

  localparam int SampleBits   = 16;
  localparam int LogTableBits = 6;
  localparam int TableSize    = 2 ** LogTableBits;
  localparam int FracBits     = 16;
  localparam int LevelBits    = 17;
  localparam int HoldBits     = 8;
  localparam int CfgIdxBits   = 2;
  localparam int CfgDataBits  = 17;

  // Magnitude of a smoothing numerator and the divide-by-three reciprocal.
  localparam int MagBits   = SampleBits + 1;
  localparam int Div3Shift = SampleBits + 1;
  localparam logic [SampleBits-1:0] Div3Mul =
    SampleBits'(((64'd1 << Div3Shift) + 64'd2) / 64'd3);

  // Deficit below full scale in log2 units, Q16.
  localparam int LzBits  = $clog2(SampleBits);
  localparam int DefBits = LzBits + FracBits;

  // 20*log10(2)/60 in Q32 (65536 * 65536 scale), and the product that uses it.
  localparam int ScaleBits = 29;
  localparam logic [ScaleBits-1:0] DbScale = ScaleBits'(430971329);
  localparam int ProdBits  = DefBits + ScaleBits;
  localparam int DeltaBits = ProdBits + 1 - 32;
  localparam logic [ProdBits:0] RoundHalf = (ProdBits + 1)'(64'd1 << 31);

  localparam logic [LevelBits-1:0] LevelFull = LevelBits'(65536);

  localparam logic                 SmoothingRst = 1'b0;
  localparam logic [HoldBits-1:0]  ClipHoldRst  = HoldBits'(32);
  localparam logic [LevelBits-1:0] ClipLevelRst = LevelBits'(64881);
  localparam logic [LevelBits-1:0] FloorLvlRst  = LevelBits'(3277);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSmoothing  = 2'd0,
    CfgClipHold   = 2'd1,
    CfgClipLevel  = 2'd2,
    CfgFloorLevel = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               zero;
    logic [DefBits-1:0] deficit;
  } defc_t;

  typedef logic [TableSize-1:0][FracBits-1:0] frac_rom_t;

  // Entry i is log2(1 + i/TableSize) in Q0.16, by repeated squaring in Q2.30.
  function automatic frac_rom_t build_frac_rom();
    frac_rom_t   rom;
    logic [63:0] x;
    rom = '0;
    for (int i = 0; i < TableSize; i++) begin
      x = (64'(TableSize) + 64'(i)) << (30 - LogTableBits);
      for (int b = FracBits - 1; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          rom[i][b] = 1'b1;
          x = x >> 1;
        end
      end
    end
    return rom;
  endfunction

  localparam frac_rom_t FracRom = build_frac_rom();

endpackage

`default_nettype wire

[rtl/sdlm_deficit.sv]
// Log2 deficit of one smoothed sample below full scale: leading-one search plus fraction table.
`default_nettype none

module sdlm_deficit
  import sdlm_pkg::*;
(
  input  logic signed [SampleBits-1:0] smooth_i,
  output defc_t                        defc_o
);

  logic [SampleBits-1:0]   mag;
  logic [LzBits-1:0]       lz;
  logic [SampleBits-1:0]   norm;
  logic [LogTableBits-1:0] idx;

  // Negative full scale folds to 2^(SampleBits-1) as an unsigned value.
  assign mag = smooth_i[SampleBits-1] ? SampleBits'(-smooth_i) : SampleBits'(smooth_i);

  always_comb begin
    lz = '0;
    for (int k = 0; k < SampleBits; k++) begin
      if (mag[k]) begin
        lz = LzBits'(SampleBits - 1 - k);
      end
    end
  end

  // Left-align the leading one; the bits below it index the table, zero-filled.
  assign norm = mag << lz;
  assign idx  = norm[SampleBits-2 -: LogTableBits];

  assign defc_o.zero    = (mag == '0);
  assign defc_o.deficit = {lz, FracBits'(0)} - DefBits'(FracRom[idx]);

endmodule

`default_nettype wire

[rtl/stereo_dbfs_level_meter.sv]
// Throughput: one stereo pair per clock unless out_stall_i backs up the pipeline; the
// smoothing loop closes through one divide-by-three reciprocal multiply into the
// smoothed-sample registers.
// Stages: smooth, log2 deficit, dB scaling multiply, level/flags/hold output register.
// Reset: asynchronous, active low; config registers go to their defaults, smoothed
// samples and the hold counter to zero, and the pipeline empties.
`default_nettype none

module stereo_dbfs_level_meter
  import sdlm_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SampleBits-1:0]  sample_left_i,
  input  logic signed [SampleBits-1:0]  sample_right_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LevelBits-1:0]          level_left_o,
  output logic [LevelBits-1:0]          level_right_o,
  output logic                          clip_left_o,
  output logic                          clip_right_o,
  output logic                          bar_left_o,
  output logic                          bar_right_o,
  output logic                          clip_hold_active_o,

  input  logic                          cfg_we_i,
  input  logic [CfgIdxBits-1:0]         cfg_idx_i,
  input  logic [CfgDataBits-1:0]        cfg_data_i
);

  // (old + x) / 2 or (2*old + x) / 3, truncated toward zero.
  function automatic logic signed [SampleBits-1:0] smooth_next(
    input logic signed [SampleBits-1:0] old,
    input logic signed [SampleBits-1:0] x,
    input logic                         sm
  );
    logic signed [SampleBits+1:0]   old_w;
    logic signed [SampleBits+1:0]   x_w;
    logic signed [SampleBits+1:0]   num;
    logic [MagBits-1:0]             mag;
    logic [MagBits+SampleBits-1:0]  prod;
    logic [MagBits-1:0]             quo;
    old_w = (SampleBits + 2)'(old);
    x_w   = (SampleBits + 2)'(x);
    num   = sm ? (old_w + old_w + x_w) : (old_w + x_w);
    mag   = num[SampleBits+1] ? MagBits'(-num) : MagBits'(num);
    prod  = (MagBits + SampleBits)'(mag) * (MagBits + SampleBits)'(Div3Mul);
    quo   = sm ? MagBits'(prod >> Div3Shift) : (mag >> 1);
    return num[SampleBits+1] ? SampleBits'(-quo) : SampleBits'(quo);
  endfunction

  // Round the scaled deficit, subtract from full scale, floor at zero.
  function automatic logic [LevelBits-1:0] level_of(
    input logic [ProdBits-1:0] prod,
    input logic                zero
  );
    logic [ProdBits:0]    sum;
    logic [DeltaBits-1:0] delta;
    sum   = (ProdBits + 1)'(prod) + RoundHalf;
    delta = sum[ProdBits:32];
    if (zero || delta >= DeltaBits'(LevelFull)) begin
      return '0;
    end
    return LevelBits'(DeltaBits'(LevelFull) - delta);
  endfunction

  // Configuration registers
  logic                 smoothing_q;
  logic [HoldBits-1:0]  clip_hold_q;
  logic [LevelBits-1:0] clip_level_q;
  logic [LevelBits-1:0] floor_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_q   <= SmoothingRst;
      clip_hold_q   <= ClipHoldRst;
      clip_level_q  <= ClipLevelRst;
      floor_level_q <= FloorLvlRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSmoothing:  smoothing_q   <= cfg_data_i[0];
        CfgClipHold:   clip_hold_q   <= cfg_data_i[HoldBits-1:0];
        CfgClipLevel:  clip_level_q  <= cfg_data_i[LevelBits-1:0];
        CfgFloorLevel: floor_level_q <= cfg_data_i[LevelBits-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage advances when it is empty or the next one advances.
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic ready1, ready2, ready3, ready4;
  logic accept, load4;

  assign ready4     = !out_valid_q || !out_stall_i;
  assign ready3     = !v3_q || ready4;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;
  assign load4      = v3_q && ready4;

  // Stage 1: smoothed samples, which are also the channel state.
  logic signed [SampleBits-1:0] smooth_l_q, smooth_r_q;
  logic signed [SampleBits-1:0] smooth_l_d, smooth_r_d;

  assign smooth_l_d = smooth_next(smooth_l_q, sample_left_i, smoothing_q);
  assign smooth_r_d = smooth_next(smooth_r_q, sample_right_i, smoothing_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      smooth_l_q <= '0;
      smooth_r_q <= '0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (accept) begin
        smooth_l_q <= smooth_l_d;
        smooth_r_q <= smooth_r_d;
      end
    end
  end

  // Stage 2: log2 deficit per channel.
  defc_t defc_l_d, defc_r_d;
  defc_t defc_l_q, defc_r_q;

  sdlm_deficit u_deficit_l (
    .smooth_i (smooth_l_q),
    .defc_o   (defc_l_d)
  );

  sdlm_deficit u_deficit_r (
    .smooth_i (smooth_r_q),
    .defc_o   (defc_r_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      defc_l_q <= defc_l_d;
      defc_r_q <= defc_r_d;
    end
  end

  // Stage 3: scale deficit to dB units of the level range.
  logic [ProdBits-1:0] prod_l_q, prod_r_q;
  logic                zero_l_q, zero_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      prod_l_q <= ProdBits'(defc_l_q.deficit) * ProdBits'(DbScale);
      prod_r_q <= ProdBits'(defc_r_q.deficit) * ProdBits'(DbScale);
      zero_l_q <= defc_l_q.zero;
      zero_r_q <= defc_r_q.zero;
    end
  end

  // Stage 4: level, threshold flags and clip hold into the output register.
  logic [LevelBits-1:0] lvl_l_d, lvl_r_d;
  logic                 clip_l_d, clip_r_d;
  logic [HoldBits-1:0]  hold_q, hold_rl, hold_d;
  logic                 active_d;

  assign lvl_l_d  = level_of(prod_l_q, zero_l_q);
  assign lvl_r_d  = level_of(prod_r_q, zero_r_q);
  assign clip_l_d = lvl_l_d >= clip_level_q;
  assign clip_r_d = lvl_r_d >= clip_level_q;

  always_comb begin
    hold_rl  = (clip_l_d || clip_r_d) ? clip_hold_q : hold_q;
    active_d = hold_rl != '0;
    hold_d   = active_d ? hold_rl - HoldBits'(1) : hold_rl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_q      <= '0;
    end else begin
      if (ready4) begin
        out_valid_q <= v3_q;
      end
      if (load4) begin
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load4) begin
      level_left_o       <= lvl_l_d;
      level_right_o      <= lvl_r_d;
      clip_left_o        <= clip_l_d;
      clip_right_o       <= clip_r_d;
      bar_left_o         <= lvl_l_d >= floor_level_q;
      bar_right_o        <= lvl_r_d >= floor_level_q;
      clip_hold_active_o <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_left_o <= LevelFull) && (level_right_o <= LevelFull))
    else $error("level beyond full scale");

  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !ready4 |=> v3_q)
    else $error("scaling stage dropped a beat while blocked");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load4 && !clip_l_d && !clip_r_d && (hold_q == '0) |=> !clip_hold_active_o)
    else $error("clip hold raised without clip or pending count");

  a_hold_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load4 && (clip_l_d || clip_r_d) && (clip_hold_q != '0)
    |=> clip_hold_active_o && (hold_q == HoldBits'($past(clip_hold_q) - HoldBits'(1))))
    else $error("clip hold counter not reloaded on clip");
`endif

endmodule

`default_nettype wire
